// File: hdl/skoc_pkg.sv
// shared widths, status codes and register map of the sorted k-mer counter
package skoc_pkg;

  localparam int KEY_W    = 64;
  localparam int CAP_W    = 11;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [CAP_W-1:0]    cap_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OCC_W-1:0]    occ_t;

  localparam status_t STATUS_FOUND    = 2'd0;
  localparam status_t STATUS_INSERTED = 2'd1;
  localparam status_t STATUS_FULL     = 2'd2;

  // register index is paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  localparam cap_t CAPACITY_RESET = 11'd1024;

endpackage

// File: hdl/skoc_table.sv
// key and count storage: one write port, one registered read port
module skoc_table #(
  parameter int DEPTH = 1024,
  parameter int DW    = 80
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/sorted_kmer_occurrence_counter_unit.sv
// top level: binary search, insert with shift, saturating increment
// each search probe reads an entry, then compares it; at most floor(log2(entries))+1 probes;
// a hit writes back the incremented count, a full table is refused, and an insert shifts
// the entries above the slot up one at a time through the one table port, then writes the key
// one item at a time; the next item is taken while a result waits
// reset (synchronous): empty table, capacity 1024, no result pending
module sorted_kmer_occurrence_counter_unit #(
  parameter int TABLE_DEPTH = 1024,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  skoc_pkg::key_t          kmer,
  output logic                    out_valid,
  input  logic                    out_ready,
  output skoc_pkg::status_t       status,
  output skoc_pkg::occ_t          occurrences,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [skoc_pkg::APB_AW-1:0] paddr,
  input  logic [skoc_pkg::APB_DW-1:0] pwdata,
  output logic [skoc_pkg::APB_DW-1:0] prdata,
  output logic                    pready
);
  import skoc_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int UW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = (UW > CAP_W) ? UW : CAP_W;
  localparam int DW = KEY_W + COUNT_WIDTH;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PROBE  = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_INSERT = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]             state;
  key_t                   key;
  logic [UW-1:0]          lo;
  logic [UW-1:0]          hi;
  logic [AW-1:0]          mid;
  logic [UW-1:0]          ptr;
  logic                   wr_pend;
  logic [AW-1:0]          wr_pend_addr;
  logic [UW-1:0]          used;
  cap_t                   capacity;
  status_t                res_status;
  occ_t                   res_occ;

  logic [UW-1:0]          mid_calc;
  logic [UW-1:0]          ptr_m1;
  logic [LW-1:0]          limit;
  logic                   is_full;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [DW-1:0]          mem_wdata;
  logic [AW-1:0]          mem_raddr;
  logic [DW-1:0]          mem_rdata;
  key_t                   rd_key;
  logic [COUNT_WIDTH-1:0] rd_cnt;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [31:0]            cnt_wide;
  logic                   cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CAPACITY) begin
      prdata = APB_DW'(capacity);
    end
  end

  // search and shift arithmetic
  assign mid_calc = lo + ((hi - lo) >> 1);
  assign ptr_m1   = ptr - UW'(1);
  assign limit    = (LW'(capacity) < LW'(TABLE_DEPTH)) ? LW'(capacity) : LW'(TABLE_DEPTH);
  assign is_full  = LW'(used) >= limit;

  assign rd_key   = mem_rdata[COUNT_WIDTH +: KEY_W];
  assign rd_cnt   = mem_rdata[COUNT_WIDTH-1:0];
  assign cnt_inc  = (rd_cnt == '1) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);
  assign cnt_wide = 32'(cnt_inc);

  // table port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = mid;
    mem_wdata = {key, cnt_inc};
    mem_raddr = mid_calc[AW-1:0];
    case (state)
      S_CMP: begin
        mem_we = (rd_key == key);
      end
      S_SHIFT: begin
        mem_we    = wr_pend;
        mem_waddr = wr_pend_addr;
        mem_wdata = mem_rdata;
        mem_raddr = ptr_m1[AW-1:0];
      end
      S_INSERT: begin
        mem_we    = 1'b1;
        mem_waddr = lo[AW-1:0];
        mem_wdata = {key, COUNT_WIDTH'(1)};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  skoc_table #(
    .DEPTH (TABLE_DEPTH),
    .DW    (DW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ready = (state == S_IDLE) && !rst;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      used    <= '0;
      wr_pend <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key   <= kmer;
            lo    <= '0;
            hi    <= used;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (lo < hi) begin
            mid   <= mid_calc[AW-1:0];
            state <= S_CMP;
          end else if (is_full) begin
            res_status <= STATUS_FULL;
            res_occ    <= '0;
            state      <= S_DONE;
          end else begin
            ptr     <= used;
            wr_pend <= 1'b0;
            state   <= S_SHIFT;
          end
        end
        S_CMP: begin
          if (rd_key == key) begin
            res_status <= STATUS_FOUND;
            res_occ    <= cnt_wide[OCC_W-1:0];
            state      <= S_DONE;
          end else begin
            if (rd_key < key) begin
              lo <= UW'(mid) + UW'(1);
            end else begin
              hi <= UW'(mid);
            end
            state <= S_PROBE;
          end
        end
        S_SHIFT: begin
          // read entry below ptr now, write it one slot up next cycle
          if (ptr > lo) begin
            ptr          <= ptr_m1;
            wr_pend      <= 1'b1;
            wr_pend_addr <= ptr[AW-1:0];
          end else begin
            wr_pend <= 1'b0;
            state   <= S_INSERT;
          end
        end
        S_INSERT: begin
          used       <= used + UW'(1);
          res_status <= STATUS_INSERTED;
          res_occ    <= OCC_W'(1);
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ready)) begin
      status      <= res_status;
      occurrences <= res_occ;
    end
  end

endmodule

// File: hdl/skoc_checker.sv
// port-level checks for the sorted k-mer counter, bound to the top level
module skoc_checker (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input skoc_pkg::status_t       status,
  input skoc_pkg::occ_t          occurrences
);
  import skoc_pkg::*;

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(occurrences))
    else $error("result beat changed while stalled");

  // not ready in the cycle after taking a key
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready straight after an accepted beat");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STATUS_FOUND || status == STATUS_INSERTED ||
                  status == STATUS_FULL)
    else $error("unknown status code");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> occurrences == '0)
    else $error("full result with non-zero count");

  a_insert_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_INSERTED |-> occurrences == OCC_W'(1))
    else $error("insert result with count other than one");

endmodule

bind sorted_kmer_occurrence_counter_unit skoc_checker u_skoc_checker (.*);

// File: sim/sorted_kmer_occurrence_counter_unit_test.sv
// self-checking testbench of the sorted k-mer occurrence counter
module sorted_kmer_occurrence_counter_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import skoc_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int COUNT_WIDTH = 16;
  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 1;
  localparam int ITEM_LATENCY = 2 * ($clog2(TABLE_DEPTH) + 1) + TABLE_DEPTH + 4;
  localparam int LONG_HOLD = 2500;
  localparam int STALL_LIMIT = 4 * (3 * ITEM_LATENCY + LONG_HOLD);
  localparam int REPEAT_BEATS = 20;
  localparam int SEGMENTS = 6;
  localparam int SEGMENT_BEATS = 80;
  localparam int TAIL_PAIRS = 8;
  localparam logic [APB_AW-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};
  localparam logic [APB_AW-1:0] UNMAPPED_ADDR = {~REG_CAPACITY, 2'b00};
  localparam key_t SAT_KEY = 64'h5A5A_C3C3_0F0F_9696;
  localparam key_t FILL_BASE = 64'hFFFF_FF00_0000_0000;
  localparam key_t FILL_STRIDE = 64'h0000_0000_0001_0001;

  typedef struct packed {
    status_t status;
    occ_t    occurrences;
  } tally_t;

  class kmer_count_scoreboard;
    key_t            keys [TABLE_DEPTH];
    longint unsigned counts [TABLE_DEPTH];
    int unsigned     used;
    cap_t            cap_reg;
    tally_t          due [$];
    int unsigned     n_found, n_inserted, n_full, n_ceiling;
    int              errors;

    function new();
      used = 0;
      cap_reg = CAPACITY_RESET;
      n_found = 0;
      n_inserted = 0;
      n_full = 0;
      n_ceiling = 0;
      errors = 0;
    endfunction

    // writes to an address outside the register map are dropped
    function void write_register(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
      if (addr[2] == REG_CAPACITY)
        cap_reg = data[CAP_W-1:0];
    endfunction

    // search, then count, insert or refuse; returns the predicted status
    function status_t note_kmer(key_t k);
      int unsigned lo, hi, mid, limit, i;
      tally_t t;
      lo = 0;
      hi = used;
      limit = (cap_reg < TABLE_DEPTH) ? cap_reg : TABLE_DEPTH;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (keys[mid] == k) begin
          if (counts[mid] < COUNT_MAX)
            counts[mid]++;
          else
            n_ceiling++;
          t = '{STATUS_FOUND, occ_t'(counts[mid])};
          due.push_back(t);
          n_found++;
          return STATUS_FOUND;
        end
        if (keys[mid] < k)
          lo = mid + 1;
        else
          hi = mid;
      end
      if (used >= limit) begin
        t = '{STATUS_FULL, occ_t'(0)};
        due.push_back(t);
        n_full++;
        return STATUS_FULL;
      end
      for (i = used; i > lo; i--) begin
        keys[i] = keys[i-1];
        counts[i] = counts[i-1];
      end
      keys[lo] = k;
      counts[lo] = 1;
      used++;
      t = '{STATUS_INSERTED, occ_t'(1)};
      due.push_back(t);
      n_inserted++;
      return STATUS_INSERTED;
    endfunction

    function void check_result(status_t s, occ_t o);
      tally_t t;
      if (due.size() == 0) begin
        $error("unexpected result beat: status %0d, occurrences %0d", s, o);
        errors++;
        return;
      end
      t = due.pop_front();
      if (s !== t.status) begin
        $error("status: expected %0d, got %0d", t.status, s);
        errors++;
      end
      if (o !== t.occurrences) begin
        $error("occurrences: expected %0d, got %0d", t.occurrences, o);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  key_t                kmer;
  logic                out_valid;
  logic                out_ready;
  status_t             status;
  occ_t                occurrences;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  kmer_count_scoreboard book = new();
  key_t known_keys [$];
  int   rx_hold = 0;
  bit   no_idle = 1'b0;
  int   idle_cycles = 0;
  int   n_settings = 0;

  sorted_kmer_occurrence_counter_unit #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kmer(kmer),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .occurrences(occurrences),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  function automatic key_t pick_kmer();
    int r;
    key_t k;
    r = $urandom_range(0, 99);
    if (r < 45 && known_keys.size() > 0) begin
      k = known_keys[$urandom_range(0, known_keys.size() - 1)];
      // near misses either side of a stored key
      if (r >= 35)
        k = $urandom_range(0, 1) ? k + key_t'(1) : k - key_t'(1);
    end else if (r < 55) begin
      case ($urandom_range(0, 3))
        0: k = '0;
        1: k = '1;
        2: k = key_t'(1) << $urandom_range(0, 63);
        default: k = ~(key_t'(1) << $urandom_range(0, 63));
      endcase
    end else begin
      k = {$urandom, $urandom};
    end
    return k;
  endfunction

  task automatic send_kmer(key_t k);
    @(negedge clk);
    in_valid <= 1'b1;
    kmer <= k;
    do @(posedge clk); while (!in_ready);
    if (book.note_kmer(k) == STATUS_INSERTED)
      known_keys.push_back(k);
  endtask

  task automatic sender_pause(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    sender_pause(1);
    while (book.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.write_register(addr, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(logic [APB_AW-1:0] addr, output logic [APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_capacity();
    logic [APB_DW-1:0] got;
    logic [APB_DW-1:0] want;
    want = {{(APB_DW - CAP_W){1'b0}}, book.cap_reg};
    apb_read(CAPACITY_ADDR, got);
    if (got !== want) begin
      $error("capacity: expected %0d, got %0d", want, got);
      book.errors++;
    end
  endtask

  task automatic set_capacity(logic [APB_DW-1:0] data);
    wait_idle();
    apb_write(CAPACITY_ADDR, data);
    check_capacity();
    n_settings++;
  endtask

  task automatic send_with_gaps(key_t k);
    send_kmer(k);
    if (!no_idle && $urandom_range(0, 9) < 3)
      sender_pause(gap_len());
  endtask

  // result side: random back-pressure, plus one long hold on request
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(negedge clk);
        rx_hold = 0;
        out_ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      book.check_result(status, occurrences);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a beat", idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int          seg;
    rst = 1'b1;
    in_valid = 1'b0;
    kmer = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    check_capacity();

    // one key hit over and over, back to back, while the table is tiny
    no_idle = 1'b1;
    for (n = 0; n < REPEAT_BEATS; n++)
      send_kmer(SAT_KEY);
    wait_idle();
    no_idle = 1'b0;

    // key extremes, neighbours and alternating patterns
    send_with_gaps('0);
    send_with_gaps('1);
    send_with_gaps('0);
    send_with_gaps('1);
    send_with_gaps(64'h8000_0000_0000_0000);
    send_with_gaps(64'h7FFF_FFFF_FFFF_FFFF);
    send_with_gaps(64'h0000_0000_0000_0001);
    send_with_gaps(64'hFFFF_FFFF_FFFF_FFFE);
    send_with_gaps(64'hAAAA_AAAA_AAAA_AAAA);
    send_with_gaps(64'h5555_5555_5555_5555);
    send_with_gaps(SAT_KEY);
    send_with_gaps(64'h8000_0000_0000_0000);

    // zero capacity: misses refused, hits still count
    set_capacity(32'd0);
    send_with_gaps(64'h0000_0000_0000_1234);
    send_with_gaps('0);

    // capacity below the fill level
    set_capacity(32'd1);
    send_with_gaps(64'hDEAD_BEEF_0000_0000);
    send_with_gaps('1);

    // write outside the register map must leave capacity alone
    wait_idle();
    apb_write(UNMAPPED_ADDR, 32'd2047);
    check_capacity();
    send_with_gaps(64'h0123_4567_89AB_CDEF);

    // room for exactly one more entry
    set_capacity(book.used + 1);
    send_with_gaps(64'h0123_4567_89AB_CDEF);
    send_with_gaps(64'hFEDC_BA98_7654_3210);

    // upper bits of the write data are not part of the register
    set_capacity(32'hFFFF_FFFF);
    send_with_gaps(64'hFEDC_BA98_7654_3210);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: set_capacity({21'd0, CAPACITY_RESET});
        1: set_capacity(book.used / 2);
        2: set_capacity({21'($urandom_range(0, 32'h1F_FFFF)), 11'h7FF});
        3: set_capacity($urandom);
        4: set_capacity(book.used + $urandom_range(5, 30));
        default: set_capacity($urandom_range(0, 2047));
      endcase
      // hold results back long enough for the block to stall its input
      if (seg == 2)
        rx_hold = LONG_HOLD;
      no_idle = (seg == 4);
      for (n = 0; n < SEGMENT_BEATS; n++)
        send_with_gaps(pick_kmer());
    end
    no_idle = 1'b0;

    // capacity above the depth, so the depth is the limit; new keys near the top
    // of the key range mixed with hits on stored ones
    set_capacity({21'($urandom_range(0, 32'h1F_FFFF)), 11'h7FF});
    for (n = 0; n < TAIL_PAIRS; n++) begin
      send_with_gaps(FILL_BASE + key_t'(n) * FILL_STRIDE);
      send_with_gaps(known_keys[$urandom_range(0, known_keys.size() - 1)]);
    end
    set_capacity({21'd0, CAPACITY_RESET});
    send_with_gaps({$urandom, $urandom});
    send_with_gaps('1);

    wait_idle();
    repeat (ITEM_LATENCY) @(posedge clk);

    $display("keys looked up: %0d counted, %0d inserted, %0d refused, %0d at the ceiling",
             book.n_found, book.n_inserted, book.n_full, book.n_ceiling);
    $display("table ended at %0d of %0d entries after %0d capacity settings",
             book.used, TABLE_DEPTH, n_settings);
    if (book.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
